// ===== rtl/teq_pkg.sv =====
// types and constants shared by the timed event queue core and its cells
package teq_pkg;

    localparam int TIME_W      = 63;
    localparam int ID_W        = 32;
    localparam int DELTA_W     = 32;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 3;
    localparam int ERR_W       = 2;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [OP_W-1:0] OP_SCHED  = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_ADV    = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MISSING = 2'd2;

    typedef logic [TIME_W-1:0] time_val_t;
    typedef logic [ID_W-1:0]   id_val_t;

    typedef struct packed {
        logic      valid;
        time_val_t due_time;
        id_val_t   task_id;
    } cell_data_t;

    typedef struct packed {
        logic ins_en;
        logic rm_en;
        logic pop_en;
    } cell_ctl_t;

    typedef struct packed {
        logic lt;
        logic le;
        logic eq;
        logic due;
    } cell_flag_t;

endpackage

// ===== rtl/teq_cell.sv =====
// one slot of the sorted task chain: compares against the key and shifts with its neighbors
module teq_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  teq_pkg::cell_ctl_t    ctl,
    input  teq_pkg::time_val_t    key_time,
    input  teq_pkg::id_val_t      key_id,
    input  teq_pkg::time_val_t    now_time,
    input  teq_pkg::cell_data_t   prev_data,
    input  logic                  prev_lt,
    input  teq_pkg::cell_data_t   next_data,
    output teq_pkg::cell_data_t   cur_data,
    output teq_pkg::cell_data_t   nxt_data,
    output teq_pkg::cell_flag_t   flag
);
    import teq_pkg::*;

    logic      valid_reg;
    time_val_t time_reg;
    id_val_t   id_reg;

    logic [TIME_W+ID_W-1:0] key_pair;
    logic [TIME_W+ID_W-1:0] cell_pair;

    assign key_pair  = {key_time, key_id};
    assign cell_pair = {time_reg, id_reg};

    assign cur_data.valid    = valid_reg;
    assign cur_data.due_time = time_reg;
    assign cur_data.task_id  = id_reg;

    assign flag.lt  = !valid_reg || (key_pair < cell_pair);
    assign flag.le  = !valid_reg || (key_pair <= cell_pair);
    assign flag.eq  = valid_reg && (key_pair == cell_pair);
    assign flag.due = valid_reg && (time_reg <= now_time);

    always_comb begin
        priority if (ctl.ins_en && flag.lt) begin
            if (prev_lt) begin
                nxt_data = prev_data;
            end else begin
                nxt_data.valid    = 1'b1;
                nxt_data.due_time = key_time;
                nxt_data.task_id  = key_id;
            end
        end else if ((ctl.rm_en && flag.le) || ctl.pop_en) begin
            nxt_data = next_data;
        end else begin
            nxt_data = cur_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= nxt_data.valid;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg <= nxt_data.due_time;
        id_reg   <= nxt_data.task_id;
    end

endmodule

// ===== rtl/timed_event_queue_core.sv =====
// timed event queue: sorted chain of task cells with a small sequencer and apb start time
// Pending tasks sit in a chain of QUEUE_DEPTH cells kept sorted by (due time, id), valid
// cells packed at the front. Schedule, cancel and query pass an accept step, then an
// execute step in which every cell compares its pair with the key in parallel and the
// chain shifts right (insert) or left (remove) by one place. Advance adds the time in
// the accept step, scans the chain for the new earliest pending time in a scan step,
// and then pops the head cell once per cycle while the result is not stalled, so the
// chain shift sets the fire rate. At most 16 tasks fire per advance; the rest stay
// pending. A stalled result holds the sequencer at its current step, but a scan with a
// due head moves on to popping. No clearing pass is needed after reset; the start time
// register at byte address 0 (64-bit data) also loads the current time when written,
// and should be written only while the block is idle.
module timed_event_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [teq_pkg::OP_W-1:0]      s_opcode,
    input  logic [teq_pkg::TIME_W-1:0]    s_due_time,
    input  logic [teq_pkg::ID_W-1:0]      s_task_id,
    input  logic [teq_pkg::DELTA_W-1:0]   s_delta,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [teq_pkg::KIND_W-1:0]    m_kind,
    output logic [teq_pkg::ID_W-1:0]      m_result_id,
    output logic [teq_pkg::TIME_W-1:0]    m_fired_time,
    output logic                          m_found,
    output logic [teq_pkg::ERR_W-1:0]     m_error,
    output logic [teq_pkg::TIME_W-1:0]    m_earliest_time,
    output logic                          m_queue_empty,
    output logic [teq_pkg::TIME_W-1:0]    m_now_time,
    output logic                          m_last
);
    import teq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_POP  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg;
    time_val_t       key_time_reg;
    id_val_t         key_id_reg;
    time_val_t       start_reg;
    time_val_t       now_reg;
    id_val_t         next_id_reg;
    time_val_t       early_reg;
    logic            empty_reg;
    logic [CNT_W-1:0] pop_cnt_reg;

    cell_data_t cur_data [QUEUE_DEPTH];
    cell_data_t nxt_data [QUEUE_DEPTH];
    cell_flag_t flags    [QUEUE_DEPTH];
    cell_ctl_t  ctl;
    id_val_t    key_id;

    logic [QUEUE_DEPTH-1:0] vld_vec;
    logic [QUEUE_DEPTH-1:0] eq_vec;
    logic                   found_any;
    logic                   full;
    logic                   out_free;
    logic                   s_fire;
    logic                   cfg_wr;
    logic [TIME_W:0]        now_sum;
    time_val_t              now_sat;
    time_val_t              bound_time;
    logic                   bound_found;
    logic                   pop_last;

    logic            res_load;
    logic [KIND_W-1:0] res_kind;
    id_val_t         res_id;
    time_val_t       res_fired;
    logic            res_found;
    logic [ERR_W-1:0] res_err;
    time_val_t       res_early;
    logic            res_empty;
    logic            res_last;

    logic             m_valid_reg;
    logic [KIND_W-1:0] m_kind_reg;
    id_val_t          m_id_reg;
    time_val_t        m_fired_reg;
    logic             m_found_reg;
    logic [ERR_W-1:0] m_err_reg;
    time_val_t        m_early_reg;
    logic             m_empty_reg;
    time_val_t        m_now_reg;
    logic             m_last_reg;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[3];
    assign prdata = paddr[3] ? 64'd0 : {1'b0, start_reg};

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign now_sum = {1'b0, now_reg} + {{(TIME_W+1-DELTA_W){1'b0}}, s_delta};
    assign now_sat = now_sum[TIME_W] ? {TIME_W{1'b1}} : now_sum[TIME_W-1:0];

    assign key_id = (op_reg == OP_SCHED) ? next_id_reg : key_id_reg;

    // cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_data_t prev_d;
        cell_data_t next_d;
        logic       prev_l;
        if (i == 0) begin : g_first
            assign prev_d = '0;
            assign prev_l = 1'b0;
        end else begin : g_mid
            assign prev_d = cur_data[i-1];
            assign prev_l = flags[i-1].lt;
        end
        if (i == QUEUE_DEPTH - 1) begin : g_end
            assign next_d = '0;
        end else begin : g_inner
            assign next_d = cur_data[i+1];
        end
        teq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .key_time  (key_time_reg),
            .key_id    (key_id),
            .now_time  (now_reg),
            .prev_data (prev_d),
            .prev_lt   (prev_l),
            .next_data (next_d),
            .cur_data  (cur_data[i]),
            .nxt_data  (nxt_data[i]),
            .flag      (flags[i])
        );
        assign vld_vec[i] = cur_data[i].valid;
        assign eq_vec[i]  = flags[i].eq;
    end

    assign found_any = |eq_vec;
    assign full      = vld_vec[QUEUE_DEPTH-1];

    // first pending cell that survives this advance
    always_comb begin
        logic prev_fire;
        logic fire;
        logic sel;
        bound_time  = '0;
        bound_found = 1'b0;
        prev_fire   = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            fire = flags[i].due && (i < MAX_RESULTS);
            sel  = cur_data[i].valid && !fire && prev_fire;
            bound_time  = bound_time | (sel ? cur_data[i].due_time : '0);
            bound_found = bound_found | sel;
            prev_fire   = fire;
        end
    end

    assign pop_last = !flags[1].due || (pop_cnt_reg == CNT_W'(MAX_RESULTS - 1));

    always_comb begin
        ctl.ins_en = (state_reg == ST_EXEC) && out_free && (op_reg == OP_SCHED)
                     && !full && !found_any;
        ctl.rm_en  = (state_reg == ST_EXEC) && out_free && (op_reg == OP_CANCEL)
                     && found_any;
        ctl.pop_en = (state_reg == ST_POP) && out_free;
    end

    // result assembly
    always_comb begin
        res_load  = 1'b0;
        res_kind  = KIND_NONE;
        res_id    = '0;
        res_fired = '0;
        res_found = 1'b0;
        res_err   = ERR_NONE;
        res_early = nxt_data[0].valid ? nxt_data[0].due_time : '0;
        res_empty = !nxt_data[0].valid;
        res_last  = 1'b1;
        unique case (state_reg)
            ST_EXEC: begin
                res_load = out_free;
                unique case (op_reg)
                    OP_SCHED: begin
                        res_kind = KIND_SCHED;
                        res_id   = full ? '0 : next_id_reg;
                        res_err  = full ? ERR_FULL : ERR_NONE;
                    end
                    OP_CANCEL: begin
                        res_kind = KIND_CANCEL;
                        res_err  = found_any ? ERR_NONE : ERR_MISSING;
                    end
                    OP_QUERY: begin
                        res_kind  = KIND_QUERY;
                        res_found = found_any;
                    end
                    default: begin
                        res_kind = KIND_NONE;
                    end
                endcase
            end
            ST_SCAN: begin
                res_load  = out_free && !flags[0].due;
                res_kind  = KIND_NONE;
                res_early = bound_time;
                res_empty = !bound_found;
            end
            ST_POP: begin
                res_load  = out_free;
                res_kind  = KIND_FIRE;
                res_id    = cur_data[0].task_id;
                res_fired = cur_data[0].due_time;
                res_early = early_reg;
                res_empty = empty_reg;
                res_last  = pop_last;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_opcode == OP_ADV) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (flags[0].due) begin
                    state_next = ST_POP;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_free && pop_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= '0;
            now_reg     <= '0;
            next_id_reg <= '0;
            pop_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= res_load || (m_valid_reg && !m_ready);
            if (cfg_wr) begin
                start_reg <= pwdata[TIME_W-1:0];
                now_reg   <= pwdata[TIME_W-1:0];
            end else if (s_fire && (s_opcode == OP_ADV)) begin
                now_reg <= now_sat;
            end
            if (ctl.ins_en || (ctl.rm_en == 1'b0 && state_reg == ST_EXEC && out_free
                               && op_reg == OP_SCHED && !full)) begin
                next_id_reg <= next_id_reg + 1'b1;
            end
            if (state_reg == ST_SCAN) begin
                pop_cnt_reg <= '0;
            end else if (ctl.pop_en) begin
                pop_cnt_reg <= pop_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg       <= s_opcode;
            key_time_reg <= s_due_time;
            key_id_reg   <= s_task_id;
        end
        if (state_reg == ST_SCAN) begin
            early_reg <= bound_time;
            empty_reg <= !bound_found;
        end
        if (res_load) begin
            m_kind_reg  <= res_kind;
            m_id_reg    <= res_id;
            m_fired_reg <= res_fired;
            m_found_reg <= res_found;
            m_err_reg   <= res_err;
            m_early_reg <= res_early;
            m_empty_reg <= res_empty;
            m_now_reg   <= now_reg;
            m_last_reg  <= res_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_result_id     = m_id_reg;
    assign m_fired_time    = m_fired_reg;
    assign m_found         = m_found_reg;
    assign m_error         = m_err_reg;
    assign m_earliest_time = m_early_reg;
    assign m_queue_empty   = m_empty_reg;
    assign m_now_time      = m_now_reg;
    assign m_last          = m_last_reg;

    // valid cells stay packed at the front of the chain
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((vld_vec + 1'b1) & vld_vec) == '0)
        else $error("cell chain has a hole");

    // a fired task is never due after the current time
    a_fire_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_FIRE) |-> (m_fired_time <= m_now_time))
        else $error("fired task not yet due");

    // a pop always takes a valid head cell
    a_pop_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop_en |-> (cur_data[0].valid && flags[0].due))
        else $error("pop of empty or not due head");

    // insert never happens into a full chain
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins_en |=> ($countones(vld_vec) == $countones($past(vld_vec)) + 1))
        else $error("insert did not add one entry");

endmodule
